// ----- rtl/rfps_pkg.sv -----
// Shared types, constants and code table for the RF remote pulse frame sender.
package rfps_pkg;

    localparam int FRAME_BITS_DEF    = 48;
    localparam int SLOTS_PER_ONE_DEF = 3;

    localparam int CODE_W     = 32;
    localparam int HI_W       = 16;
    localparam int FRAME_W    = CODE_W + HI_W;
    localparam int REPEAT_W   = 4;
    localparam int SLOT_W     = 6;
    localparam int SEL_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [REPEAT_W-1:0] REPEAT_RST   = 4'd6;
    localparam logic [SLOT_W-1:0]   PREAMBLE_RST = 6'd26;
    localparam logic [HI_W-1:0]     ON_CODE_RST  = 16'd13107;
    localparam logic [HI_W-1:0]     OFF_CODE_RST = 16'd21299;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPEAT_COUNT   = 2'd0,
        REG_PREAMBLE_SLOTS = 2'd1,
        REG_ON_CODE        = 2'd2,
        REG_OFF_CODE       = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REFUSE = 2'd2
    } cmd_status_t;

    typedef enum logic [0:0] {
        OP_CMD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic [REPEAT_W-1:0] repeat_count;
        logic [SLOT_W-1:0]   preamble_slots;
        logic [HI_W-1:0]     on_code;
        logic [HI_W-1:0]     off_code;
    } cfg_t;

    typedef struct packed {
        logic        line_level;
        logic        busy_res;
        cmd_status_t cmd_status;
    } res_t;

    localparam logic [CODE_W-1:0] CODE_TABLE [16] = '{
        32'd859124533, 32'd861090613, 32'd892547893, 32'd1395864373,
        32'd859124563, 32'd861090643, 32'd892547923, 32'd1395864403,
        32'd859125043, 32'd861091123, 32'd892548403, 32'd1395864883,
        32'd859132723, 32'd861098803, 32'd892556083, 32'd1395872563
    };

endpackage

// ----- rtl/rfps_cfg.sv -----
// Configuration register file for the frame sender.
module rfps_cfg
    import rfps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_count   <= REPEAT_RST;
            cfg_reg.preamble_slots <= PREAMBLE_RST;
            cfg_reg.on_code        <= ON_CODE_RST;
            cfg_reg.off_code       <= OFF_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_REPEAT_COUNT:   cfg_reg.repeat_count   <= cfg_data[REPEAT_W-1:0];
                REG_PREAMBLE_SLOTS: cfg_reg.preamble_slots <= cfg_data[SLOT_W-1:0];
                REG_ON_CODE:        cfg_reg.on_code        <= cfg_data[HI_W-1:0];
                REG_OFF_CODE:       cfg_reg.off_code       <= cfg_data[HI_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- rtl/rfps_seq.sv -----
// Frame sequencer: command decode, slot state and per-transaction result.
module rfps_seq
    import rfps_pkg::*;
#(
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    parameter int SLOTS_PER_ONE = SLOTS_PER_ONE_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             op,
    input  logic [SEL_W-1:0] channel,
    input  logic [SEL_W-1:0] button,
    input  logic             switch_on,
    input  cfg_t             cfg,
    output res_t             res
);

    localparam int BIDX_W = $clog2(FRAME_BITS);
    localparam int EXT_W  = 1 << BIDX_W;
    localparam logic [SLOT_W-1:0] ONE_LEN    = SLOT_W'(SLOTS_PER_ONE);
    localparam logic [BIDX_W:0]   FRAME_LAST = (BIDX_W + 1)'(FRAME_BITS);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PRE  = 4'b0010,
        PH_SYNC = 4'b0100,
        PH_BITS = 4'b1000
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [FRAME_W-1:0]  frame_reg,   frame_next;
    logic [SLOT_W-1:0]   slot_reg,    slot_next;
    logic [BIDX_W-1:0]   bit_reg,     bit_next;
    logic [REPEAT_W-1:0] repeats_reg, repeats_next;
    logic                level_reg,   level_next;

    logic [EXT_W-1:0]    frame_ext;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   pre_len;
    logic [BIDX_W:0]     bit_inc;
    logic [REPEAT_W-1:0] rep_dec;
    logic [1:0]          ch_lo;
    logic [1:0]          bt_lo;
    logic                bit_done;
    logic                sel_ok;
    cmd_status_t         status;

    always_comb
    begin
        frame_ext    = EXT_W'(frame_reg);
        slot_inc     = slot_reg + 1'b1;
        pre_len      = (cfg.preamble_slots == '0) ? SLOT_W'(1) : cfg.preamble_slots;
        bit_inc      = {1'b0, bit_reg} + 1'b1;
        rep_dec      = (repeats_reg != '0) ? repeats_reg - 1'b1 : '0;
        ch_lo        = 2'(channel - 1'b1);
        bt_lo        = 2'(button - 1'b1);
        sel_ok       = (channel >= SEL_W'(1)) && (channel <= SEL_W'(4))
                    && (button >= SEL_W'(1)) && (button <= SEL_W'(4));
        bit_done     = frame_ext[bit_reg] ? (slot_inc >= ONE_LEN) : 1'b1;

        phase_next   = phase_reg;
        frame_next   = frame_reg;
        slot_next    = slot_reg;
        bit_next     = bit_reg;
        repeats_next = repeats_reg;
        level_next   = level_reg;
        status       = ST_NONE;

        if (op_t'(op) == OP_CMD)
        begin
            if ((phase_reg != PH_IDLE) || !sel_ok)
            begin
                status = ST_REFUSE;
            end
            else
            begin
                frame_next   = {(switch_on ? cfg.on_code : cfg.off_code),
                                CODE_TABLE[{ch_lo, bt_lo}]};
                repeats_next = (cfg.repeat_count == '0) ? REPEAT_W'(1) : cfg.repeat_count;
                phase_next   = PH_PRE;
                slot_next    = '0;
                bit_next     = '0;
                status       = ST_ACCEPT;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_PRE:
                begin
                    level_next = 1'b0;
                    slot_next  = slot_inc;
                    if (slot_inc >= pre_len)
                    begin
                        slot_next  = '0;
                        phase_next = PH_SYNC;
                    end
                end
                PH_SYNC:
                begin
                    level_next = 1'b1;
                    slot_next  = '0;
                    bit_next   = '0;
                    phase_next = PH_BITS;
                end
                PH_BITS:
                begin
                    level_next = bit_reg[0];
                    slot_next  = slot_inc;
                    if (bit_done)
                    begin
                        slot_next = '0;
                        bit_next  = bit_inc[BIDX_W-1:0];
                        if (bit_inc >= FRAME_LAST)
                        begin
                            bit_next     = '0;
                            repeats_next = rep_dec;
                            phase_next   = (rep_dec == '0) ? PH_IDLE : PH_PRE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        res.line_level = level_next;
        res.busy_res   = (phase_next != PH_IDLE);
        res.cmd_status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            frame_reg   <= '0;
            slot_reg    <= '0;
            bit_reg     <= '0;
            repeats_reg <= '0;
            level_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            frame_reg   <= frame_next;
            slot_reg    <= slot_next;
            bit_reg     <= bit_next;
            repeats_reg <= repeats_next;
            level_reg   <= level_next;
        end
    end

endmodule

// ----- rtl/rfps_out.sv -----
// Result register with valid/stall handshake towards the receiver.
module rfps_out
    import rfps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  accept,
    input  res_t  res,
    output logic  out_valid,
    input  logic  out_stall,
    output res_t  out_res
);

    logic out_valid_reg, out_valid_next;
    res_t res_reg;

    assign in_stall       = out_valid_reg && out_stall;
    assign accept         = in_valid && !in_stall;
    assign out_valid_next = accept || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign out_res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- rtl/rf_remote_pulse_frame_sender_top.sv -----
// Top level of the RF remote pulse frame sender.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  input   | in        | in_valid / in_stall | op, channel, button, switch_on
//  result  | out       | out_valid/out_stall | line_level, busy_res, cmd_status
//  config  | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One transaction per cycle unless stalled; result in the cycle after acceptance.
//  Throughput is set by the single result register: one per cycle unless stalled.
//  in_stall is high only while a held result is stalled by the receiver.
//  Asynchronous active-low reset: sequencer idle, its level low, config at defaults.
//  cfg_ready is always high; writes take effect on the next cycle.
module rf_remote_pulse_frame_sender_top
    import rfps_pkg::*;
#(
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    parameter int SLOTS_PER_ONE = SLOTS_PER_ONE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [SEL_W-1:0]      channel,
    input  logic [SEL_W-1:0]      button,
    input  logic                  switch_on,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  line_level,
    output logic                  busy_res,
    output logic [1:0]            cmd_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic accept;

    rfps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfps_seq #(
        .FRAME_BITS    (FRAME_BITS),
        .SLOTS_PER_ONE (SLOTS_PER_ONE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .channel   (channel),
        .button    (button),
        .switch_on (switch_on),
        .cfg       (cfg),
        .res       (res)
    );

    rfps_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accept    (accept),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign line_level = out_res.line_level;
    assign busy_res   = out_res.busy_res;
    assign cmd_status = out_res.cmd_status;

endmodule

// ----- rtl/rfps_chk.sv -----
// Port-level checker for the frame sender, bound to the top level.
module rfps_chk
    import rfps_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  line_level,
    input logic                  busy_res,
    input logic [1:0]            cmd_status
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_level)
            && $stable(busy_res) && $stable(cmd_status))
        else $error("stalled result changed");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transaction produced no result");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cmd_status == ST_ACCEPT) |-> busy_res)
        else $error("accepted command not busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cmd_status == ST_NONE) || (cmd_status == ST_ACCEPT)
            || (cmd_status == ST_REFUSE))
        else $error("undefined command status");

endmodule

bind rf_remote_pulse_frame_sender_top rfps_chk u_rfps_chk (.*);

// ----- dv/tb_frame_pkg.sv -----
// Scoreboard for the RF remote frame sender: slot-level predictor and result check.
package tb_frame_pkg;
    import rfps_pkg::*;

    typedef enum logic [1:0] {
        SEQ_IDLE     = 2'd0,
        SEQ_PREAMBLE = 2'd1,
        SEQ_SYNC     = 2'd2,
        SEQ_DATA     = 2'd3
    } seq_phase_t;

    class frame_scoreboard;
        cfg_t               regs;
        logic [FRAME_W-1:0] frame;
        seq_phase_t         seq;
        int unsigned        slot_cnt;
        int unsigned        bit_idx;
        int unsigned        reps_left;
        logic               lvl;
        res_t               expected_q[$];
        int                 errors;
        int                 seen;

        function new();
            regs      = '{REPEAT_RST, PREAMBLE_RST, ON_CODE_RST, OFF_CODE_RST};
            frame     = '0;
            seq       = SEQ_IDLE;
            slot_cnt  = 0;
            bit_idx   = 0;
            reps_left = 0;
            lvl       = 1'b0;
            errors    = 0;
            seen      = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_REPEAT_COUNT:   regs.repeat_count   = data[REPEAT_W-1:0];
                REG_PREAMBLE_SLOTS: regs.preamble_slots = data[SLOT_W-1:0];
                REG_ON_CODE:        regs.on_code        = data[HI_W-1:0];
                REG_OFF_CODE:       regs.off_code       = data[HI_W-1:0];
                default: ;
            endcase
        endfunction

        function bit idle();
            return seq == SEQ_IDLE;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void restart_frame();
            seq      = SEQ_PREAMBLE;
            slot_cnt = 0;
            bit_idx  = 0;
        endfunction

        function void advance_slot();
            int unsigned pre_len;
            int unsigned bit_len;
            case (seq)
                SEQ_PREAMBLE:
                begin
                    lvl = 1'b0;
                    slot_cnt++;
                    pre_len = (regs.preamble_slots == 0) ? 1 : regs.preamble_slots;
                    if (slot_cnt >= pre_len)
                    begin
                        slot_cnt = 0;
                        seq      = SEQ_SYNC;
                    end
                end
                SEQ_SYNC:
                begin
                    lvl      = 1'b1;
                    slot_cnt = 0;
                    bit_idx  = 0;
                    seq      = SEQ_DATA;
                end
                SEQ_DATA:
                begin
                    lvl     = bit_idx[0];
                    bit_len = frame[bit_idx] ? SLOTS_PER_ONE_DEF : 1;
                    slot_cnt++;
                    if (slot_cnt >= bit_len)
                    begin
                        slot_cnt = 0;
                        bit_idx++;
                        if (bit_idx >= FRAME_BITS_DEF)
                        begin
                            bit_idx = 0;
                            if (reps_left > 0)
                                reps_left--;
                            if (reps_left == 0)
                                seq = SEQ_IDLE;
                            else
                                restart_frame();
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_input(op_t op, logic [SEL_W-1:0] ch, logic [SEL_W-1:0] bt,
                                 logic on);
            cmd_status_t     status;
            res_t            exp_res;
            int unsigned     idx;
            logic [HI_W-1:0] hi;
            status = ST_NONE;
            if (op == OP_CMD)
            begin
                if (seq != SEQ_IDLE || ch < 1 || ch > 4 || bt < 1 || bt > 4)
                    status = ST_REFUSE;
                else
                begin
                    idx       = (ch - 1) * 4 + (bt - 1);
                    hi        = on ? regs.on_code : regs.off_code;
                    frame     = {hi, CODE_TABLE[idx]};
                    reps_left = (regs.repeat_count == 0) ? 1 : regs.repeat_count;
                    restart_frame();
                    status = ST_ACCEPT;
                end
            end
            else
                advance_slot();
            exp_res.line_level = lvl;
            exp_res.busy_res   = (seq != SEQ_IDLE);
            exp_res.cmd_status = status;
            expected_q.push_back(exp_res);
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", seen, msg);
            errors++;
        endtask

        task check_result(logic level, logic busy, logic [1:0] status);
            res_t exp_res;
            seen++;
            if (expected_q.size() == 0)
                report("result with no transaction outstanding");
            else
            begin
                exp_res = expected_q.pop_front();
                if (level !== exp_res.line_level)
                    report($sformatf("line_level %b, want %b", level, exp_res.line_level));
                if (busy !== exp_res.busy_res)
                    report($sformatf("busy_res %b, want %b", busy, exp_res.busy_res));
                if (status !== exp_res.cmd_status)
                    report($sformatf("cmd_status %0d, want %0d", status,
                                     exp_res.cmd_status));
            end
        endtask
    endclass

endpackage

// ----- dv/tb_top.sv -----
// Top-level testbench for the RF remote frame sender: stimulus, handshakes and final verdict.
module tb_top;
    import rfps_pkg::*;
    import tb_frame_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic [SEL_W-1:0]      channel;
    logic [SEL_W-1:0]      button;
    logic                  switch_on;
    logic                  out_valid;
    logic                  out_stall;
    logic                  line_level;
    logic                  busy_res;
    logic [1:0]            cmd_status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int              gap_odds = 0;
    frame_scoreboard sb = new();

    rf_remote_pulse_frame_sender_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .channel    (channel),
        .button     (button),
        .switch_on  (switch_on),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_level (line_level),
        .busy_res   (busy_res),
        .cmd_status (cmd_status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic send_item(op_t o, logic [SEL_W-1:0] ch, logic [SEL_W-1:0] bt, logic on);
        @(negedge clk);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid  = 1'b1;
        op        = o;
        channel   = ch;
        button    = bt;
        switch_on = on;
        do @(posedge clk); while (in_stall);
        sb.note_input(o, ch, bt, on);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_regs(logic [CFG_DATA_W-1:0] reps, logic [CFG_DATA_W-1:0] pre,
                             logic [CFG_DATA_W-1:0] on_val, logic [CFG_DATA_W-1:0] off_val);
        settle();
        write_reg(REG_REPEAT_COUNT, reps);
        write_reg(REG_PREAMBLE_SLOTS, pre);
        write_reg(REG_ON_CODE, on_val);
        write_reg(REG_OFF_CODE, off_val);
    endtask

    task automatic run_random(int n);
        bit               do_cmd;
        logic [SEL_W-1:0] ch;
        logic [SEL_W-1:0] bt;
        repeat (n)
        begin
            if (sb.idle())
                do_cmd = ($urandom_range(0, 9) < 6);
            else
                do_cmd = ($urandom_range(0, 19) == 0);
            if (do_cmd)
            begin
                ch = SEL_W'($urandom_range(1, 4));
                bt = SEL_W'($urandom_range(1, 4));
                if ($urandom_range(0, 7) == 0)
                begin
                    ch = SEL_W'($urandom_range(0, 7));
                    bt = SEL_W'($urandom_range(0, 7));
                end
                send_item(OP_CMD, ch, bt, 1'($urandom_range(0, 1)));
            end
            else
                send_item(OP_TICK, SEL_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                hold = $urandom_range(1, 19);
            out_stall = (hold > 0);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(line_level, busy_res, cmd_status);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_TICK;
        channel   = '0;
        button    = '0;
        switch_on = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_REPEAT_COUNT;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(OP_TICK, 3'd0, 3'd0, 1'b0);
        send_item(OP_CMD, 3'd0, 3'd1, 1'b1);
        send_item(OP_CMD, 3'd1, 3'd0, 1'b0);
        send_item(OP_CMD, 3'd5, 3'd2, 1'b1);
        send_item(OP_CMD, 3'd3, 3'd7, 1'b0);
        send_item(OP_CMD, 3'd7, 3'd7, 1'b1);
        send_item(OP_CMD, 3'd1, 3'd1, 1'b0);
        send_item(OP_CMD, 3'd4, 3'd4, 1'b1);
        repeat (10) send_item(OP_TICK, 3'd7, 3'd7, 1'b1);
        send_item(OP_CMD, 3'd2, 3'd3, 1'b1);

        gap_odds = 8;
        run_random(150);

        load_regs(16'd1, 16'd1, 16'hFFFF, 16'h0000);
        gap_odds = 0;
        run_random(250);

        load_regs(16'hFFF0, 16'hFFC0, 16'($urandom), 16'($urandom));
        gap_odds = 6;
        run_random(250);

        load_regs(16'd2, 16'd63, 16'h0000, 16'hFFFF);
        gap_odds = 12;
        run_random(150);

        load_regs(16'd15, 16'd1, 16'($urandom), 16'($urandom));
        gap_odds = 0;
        run_random(650);

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rfps_pkg.sv
rtl/rfps_cfg.sv
rtl/rfps_seq.sv
rtl/rfps_out.sv
rtl/rf_remote_pulse_frame_sender_top.sv
rtl/rfps_chk.sv
dv/tb_frame_pkg.sv
dv/tb_top.sv
